// File: src/mbtd_pkg.sv
// ---------------------------------------------------------------------------
// mbtd_pkg
// shared types, constants and helpers of the mixed binary/text deframer
// ---------------------------------------------------------------------------
package mbtd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W = 32;
    localparam int unsigned MAX_RECS = 4;
    localparam int unsigned CNT_W = $clog2(MAX_RECS + 1);
    localparam int unsigned IDX_W = $clog2(MAX_RECS);

    localparam int unsigned MBTD_LENGTH_BYTES = 4;
    localparam int unsigned MBTD_QUEUE_DEPTH = 4;

    localparam logic [BYTE_W-1:0] START_CODE_RESET = 8'h24;
    localparam logic [BYTE_W-1:0] TERM_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] TERM_LF = 8'h0A;

    localparam logic REC_DATA = 1'b0;
    localparam logic REC_END = 1'b1;
    localparam logic PKT_TEXT = 1'b0;
    localparam logic PKT_BINARY = 1'b1;

    typedef struct packed {
        logic              kind;
        logic              ptype;
        logic [BYTE_W-1:0] data;
    } rec_t;

    typedef struct packed {
        logic [CNT_W-1:0]       cnt;
        rec_t [MAX_RECS-1:0]    rec;
    } bundle_t;

    function automatic rec_t mk_rec(logic kind, logic ptype, logic [BYTE_W-1:0] data);
        rec_t r;
        r.kind = kind;
        r.ptype = ptype;
        r.data = data;
        return r;
    endfunction

endpackage

// File: src/mbtd_if.sv
// ---------------------------------------------------------------------------
// mbtd stream interfaces
// valid/ready channels for stream bytes and output records
// ---------------------------------------------------------------------------
interface mbtd_byte_if
    import mbtd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface mbtd_rec_if
    import mbtd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              record_kind;
    logic              packet_type;
    logic [BYTE_W-1:0] data_byte;
    logic              run_last;

    modport source (output valid, output record_kind, output packet_type,
                    output data_byte, output run_last, input ready);
    modport sink (input valid, input record_kind, input packet_type,
                  input data_byte, input run_last, output ready);
endinterface

// File: src/mbtd_front.sv
// ---------------------------------------------------------------------------
// mbtd_front
// takes stream bytes, tracks framing state and builds record bundles
// ---------------------------------------------------------------------------
module mbtd_front
    import mbtd_pkg::*;
#(
    parameter int unsigned LENGTH_BYTES = MBTD_LENGTH_BYTES
) (
    input  logic              clk,
    input  logic              rst_n,
    mbtd_byte_if.sink         in_ch,
    input  logic              cfg_we,
    input  logic [BYTE_W-1:0] cfg_wdata,
    input  logic              q_full,
    output logic              q_push,
    output bundle_t           q_data
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_BINARY,
        PH_TEXT
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [1:0]        hdr_cnt_reg, hdr_cnt_next;
    logic [LEN_W-1:0]  accum_reg, accum_next;
    logic [LEN_W-1:0]  remain_reg, remain_next;
    logic [1:0]        match_reg, match_next;
    logic [BYTE_W-1:0] start_code_reg;

    logic              accept;
    logic [BYTE_W-1:0] b;
    logic [1:0]        tm;
    logic [BYTE_W-1:0] expect_byte;
    bundle_t           t_bundle;
    logic [1:0]        t_match;
    logic              t_end;
    logic              hdr_last;
    bundle_t           bundle;

    assign in_ch.ready = !q_full;
    assign accept = in_ch.valid && in_ch.ready;
    assign b = in_ch.in_byte;

    // text terminator prefix tracker
    assign tm = (phase_reg == PH_IDLE) ? 2'd0 : match_reg;
    assign expect_byte = tm[0] ? TERM_LF : TERM_CR;

    always_comb
    begin
        t_bundle = '0;
        t_match = 2'd0;
        t_end = 1'b0;
        if (b == expect_byte)
        begin
            if (tm == 2'd3)
            begin
                t_end = 1'b1;
                t_bundle.cnt = CNT_W'(1);
                t_bundle.rec[0] = mk_rec(REC_END, PKT_TEXT, '0);
            end
            else
            begin
                t_match = tm + 2'd1;
            end
        end
        else
        begin
            case (tm)
                2'd0:
                begin
                    t_bundle.cnt = CNT_W'(1);
                    t_bundle.rec[0] = mk_rec(REC_DATA, PKT_TEXT, b);
                end
                2'd1:
                begin
                    t_bundle.rec[0] = mk_rec(REC_DATA, PKT_TEXT, TERM_CR);
                    if (b == TERM_CR)
                    begin
                        t_bundle.cnt = CNT_W'(1);
                        t_match = 2'd1;
                    end
                    else
                    begin
                        t_bundle.cnt = CNT_W'(2);
                        t_bundle.rec[1] = mk_rec(REC_DATA, PKT_TEXT, b);
                    end
                end
                2'd2:
                begin
                    t_bundle.cnt = CNT_W'(3);
                    t_bundle.rec[0] = mk_rec(REC_DATA, PKT_TEXT, TERM_CR);
                    t_bundle.rec[1] = mk_rec(REC_DATA, PKT_TEXT, TERM_LF);
                    t_bundle.rec[2] = mk_rec(REC_DATA, PKT_TEXT, b);
                end
                default:
                begin
                    t_bundle.rec[0] = mk_rec(REC_DATA, PKT_TEXT, TERM_CR);
                    t_bundle.rec[1] = mk_rec(REC_DATA, PKT_TEXT, TERM_LF);
                    t_bundle.rec[2] = mk_rec(REC_DATA, PKT_TEXT, TERM_CR);
                    if (b == TERM_CR)
                    begin
                        t_bundle.cnt = CNT_W'(3);
                        t_match = 2'd1;
                    end
                    else
                    begin
                        t_bundle.cnt = CNT_W'(4);
                        t_bundle.rec[3] = mk_rec(REC_DATA, PKT_TEXT, b);
                    end
                end
            endcase
        end
    end

    assign hdr_last = (32'(hdr_cnt_reg) + 32'd1) >= 32'(LENGTH_BYTES);

    always_comb
    begin
        phase_next = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        accum_next = accum_reg;
        remain_next = remain_reg;
        match_next = match_reg;
        bundle = '0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (b == start_code_reg)
                begin
                    phase_next = PH_HEADER;
                    hdr_cnt_next = 2'd0;
                    accum_next = '0;
                end
                else
                begin
                    bundle = t_bundle;
                    match_next = t_match;
                    phase_next = t_end ? PH_IDLE : PH_TEXT;
                end
            end
            PH_HEADER:
            begin
                accum_next = {accum_reg[LEN_W-BYTE_W-1:0], b};
                if (hdr_last)
                begin
                    hdr_cnt_next = 2'd0;
                    remain_next = accum_next;
                    if (accum_next == '0)
                    begin
                        phase_next = PH_IDLE;
                        bundle.cnt = CNT_W'(1);
                        bundle.rec[0] = mk_rec(REC_END, PKT_BINARY, '0);
                    end
                    else
                    begin
                        phase_next = PH_BINARY;
                    end
                end
                else
                begin
                    hdr_cnt_next = hdr_cnt_reg + 2'd1;
                end
            end
            PH_BINARY:
            begin
                bundle.rec[0] = mk_rec(REC_DATA, PKT_BINARY, b);
                remain_next = (remain_reg != '0) ? remain_reg - LEN_W'(1) : '0;
                if (remain_reg <= LEN_W'(1))
                begin
                    phase_next = PH_IDLE;
                    bundle.cnt = CNT_W'(2);
                    bundle.rec[1] = mk_rec(REC_END, PKT_BINARY, '0);
                end
                else
                begin
                    bundle.cnt = CNT_W'(1);
                end
            end
            default:
            begin
                bundle = t_bundle;
                match_next = t_match;
                if (t_end)
                begin
                    phase_next = PH_IDLE;
                end
            end
        endcase
    end

    assign q_push = accept && (bundle.cnt != '0);
    assign q_data = bundle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            hdr_cnt_reg <= 2'd0;
            accum_reg <= '0;
            remain_reg <= '0;
            match_reg <= 2'd0;
            start_code_reg <= START_CODE_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                start_code_reg <= cfg_wdata;
            end
            if (accept)
            begin
                phase_reg <= phase_next;
                hdr_cnt_reg <= hdr_cnt_next;
                accum_reg <= accum_next;
                remain_reg <= remain_next;
                match_reg <= match_next;
            end
        end
    end

`ifndef SYNTH
    a_match_only_in_text: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_TEXT) |-> (match_reg == 2'd0))
        else $error("terminator match held outside a text packet");

    a_bundle_count: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_data.cnt <= CNT_W'(MAX_RECS)))
        else $error("bundle holds too many records");
`endif

endmodule

// File: src/mbtd_queue.sv
// ---------------------------------------------------------------------------
// mbtd_queue
// short queue of record bundles between classifier and record emitter
// ---------------------------------------------------------------------------
module mbtd_queue
    import mbtd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = MBTD_QUEUE_DEPTH
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    empty,
    output bundle_t head
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

    bundle_t           mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head = mem_reg[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("bundle written into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("bundle taken from an empty queue");
`endif

endmodule

// File: src/mbtd_back.sv
// ---------------------------------------------------------------------------
// mbtd_back
// unpacks queued bundles into one output record per transfer
// ---------------------------------------------------------------------------
module mbtd_back
    import mbtd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  bundle_t   q_head,
    output logic      q_pop,
    mbtd_rec_if.source out_ch
);

    logic             out_valid_reg;
    rec_t             rec_reg;
    logic             run_last_reg;
    logic [IDX_W-1:0] idx_reg;

    logic             load;
    logic             last;

    assign load = !q_empty && (!out_valid_reg || out_ch.ready);
    assign last = (CNT_W'(idx_reg) + CNT_W'(1)) == q_head.cnt;
    assign q_pop = load && last;

    assign out_ch.valid = out_valid_reg;
    assign out_ch.record_kind = rec_reg.kind;
    assign out_ch.packet_type = rec_reg.ptype;
    assign out_ch.data_byte = rec_reg.data;
    assign out_ch.run_last = run_last_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg <= q_head.rec[idx_reg];
            run_last_reg <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg <= last ? '0 : idx_reg + IDX_W'(1);
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_end_record_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rec_reg.kind == REC_END) |-> (rec_reg.data == '0))
        else $error("end record carries a data byte");

    a_end_record_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rec_reg.kind == REC_END) |-> run_last_reg)
        else $error("end record not marked as last of its byte");
`endif

endmodule

// File: src/mixed_binary_text_deframer_core.sv
// ---------------------------------------------------------------------------
// mixed_binary_text_deframer_core
// deframes length-prefixed binary and CR LF CR LF terminated text packets
// ---------------------------------------------------------------------------
// path: records of a byte pass through the bundle queue and the output register
// throughput: one byte per cycle while out_ch is ready and each byte yields at
//   most one record; output runs at one record per cycle while out_ch is ready,
//   and a byte with n records takes n output transfers, buffered by the bundle queue (QUEUE_DEPTH bundles)
// reset: asynchronous, clears framing state and queue, start code to 0x24
// ---------------------------------------------------------------------------
module mixed_binary_text_deframer_core
    import mbtd_pkg::*;
#(
    parameter int unsigned LENGTH_BYTES = MBTD_LENGTH_BYTES,
    parameter int unsigned QUEUE_DEPTH = MBTD_QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    mbtd_byte_if.sink         in_ch,
    mbtd_rec_if.source        out_ch,
    input  logic              cfg_we,
    input  logic [BYTE_W-1:0] cfg_wdata
);

    logic    q_push;
    bundle_t q_data;
    logic    q_full;
    logic    q_pop;
    logic    q_empty;
    bundle_t q_head;

    mbtd_front #(
        .LENGTH_BYTES (LENGTH_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_data)
    );

    mbtd_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    mbtd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

endmodule
